// ===== rtl/core/time_weighted_tail_accumulator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the time-weighted tail accumulator
// Implication checks on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIME_WEIGHTED_TAIL_ACCUMULATOR_UNIT_ASSERT_SVH
`define TIME_WEIGHTED_TAIL_ACCUMULATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TWTA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TWTA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/twta_pkg.sv =====
// ----------------------------------------------------------------------------
// twta_pkg
// Widths, limits and codes of the time-weighted tail accumulator.
// ----------------------------------------------------------------------------
package twta_pkg;

    localparam int MAX_BUCKET_BLOCKS = 4096;

    // field widths
    localparam int SIZE_W  = 13;
    localparam int BIDX_W  = 28;
    localparam int BLK_W   = 40;
    localparam int EXP_W   = 36;
    localparam int HOLD_W  = 48;
    localparam int TOK_W   = 16;
    localparam int EACC_W  = 48;
    localparam int HACC_W  = 61;
    localparam int TACC_W  = 28;
    localparam int WACC_W  = 13;

    // stream widths
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 152;
    localparam int OUT_PAD_W  = OUT_DATA_W - (EACC_W + HACC_W + TACC_W + WACC_W);

    // internal widths
    localparam int POS_W  = BLK_W + 1;   // bucket low and end block
    localparam int LEN_W  = 13;          // span length, at most MAX_BUCKET_BLOCKS
    localparam int TRI_W  = 23;          // len*(len-1)/2
    localparam int HALF_W = HOLD_W / 2;  // holding operand is split in halves
    localparam int MA_W   = 36;
    localparam int MB_W   = 24;
    localparam int PROD_W = MA_W + MB_W;

    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [PROD_W-1:0] t_prod;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LO    = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_LEN   = 3'd3;
    localparam logic [2:0] S_RUN   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    // multiplier operations within one span
    localparam logic [2:0] OP_TRI  = 3'd0;
    localparam logic [2:0] OP_EXP  = 3'd1;
    localparam logic [2:0] OP_HLO  = 3'd2;
    localparam logic [2:0] OP_HHI  = 3'd3;
    localparam logic [2:0] OP_TOK  = 3'd4;
    localparam logic [2:0] OP_HTRI = 3'd5;

    // spans
    localparam logic [1:0] SPAN_DEL = 2'd0;  // old tail, removed
    localparam logic [1:0] SPAN_OLD = 2'd1;  // old sample, real span
    localparam logic [1:0] SPAN_NEW = 2'd2;  // new sample, tail to end block

endpackage

// ===== rtl/core/time_weighted_tail_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// time_weighted_tail_accumulator_unit
// Four time-weighted sums of one bucket, kept filled to the bucket end block.
// ----------------------------------------------------------------------------
// One word is taken at a time and the input is not ready until its result is
// in the output register. A single 36x24 multiplier, reused under a small
// sequencer, sets the pace: six products per span (triangle number, exposure,
// two holding halves, tokens, slope times triangle). A dropped word skips the
// spans, a word with no tail held (first word of a bucket) runs only the new
// span and any other word runs all three, and the next word is also held back
// while the previous result waits on the output. The bucket size register may
// be written only while the block is idle; its ready is always high.
module time_weighted_tail_accumulator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // bucket_index, event_block, exposure, holding_exposure, token_count
    input  logic [twta_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // start_bucket
    input  logic [0:0]                        s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // exposure_time_sum, holding_time_sum, token_time_sum, weight_sum, zero pad
    output logic [twta_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // rejected
    output logic [0:0]                        m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [twta_pkg::SIZE_W-1:0]       i_cfg_data
);
    import twta_pkg::*;

    logic [2:0]          r_state, n_state;
    logic [SIZE_W-1:0]   r_cfg_size;
    logic [SIZE_W-1:0]   r_size;
    logic [SIZE_W-1:0]   size_eff;

    logic [BIDX_W-1:0]   r_in_bidx;
    logic [BLK_W-1:0]    r_in_blk;
    logic [EXP_W-1:0]    r_in_exp;
    logic [HOLD_W-1:0]   r_in_hold;
    logic [TOK_W-1:0]    r_in_tok;

    logic                r_tail_valid;
    logic [BLK_W-1:0]    r_prev_blk;
    logic [EXP_W-1:0]    r_prev_exp;
    logic [HOLD_W-1:0]   r_prev_hold;
    logic [TOK_W-1:0]    r_prev_tok;

    logic [EACC_W-1:0]   r_exp_acc;
    logic [HACC_W-1:0]   r_hold_acc;
    logic [TACC_W-1:0]   r_tok_acc;
    logic [WACC_W-1:0]   r_wgt_acc;

    t_pos                r_end;
    logic                r_rej;
    t_len                r_l_del, r_l_old, r_l_new;
    logic [TRI_W-1:0]    r_tri;
    logic [1:0]          r_span;
    logic [2:0]          r_op;

    t_prod               r_prod;
    logic                r_pv;
    logic [2:0]          r_pkind;
    logic                r_psub;

    logic                r_ovalid;
    logic [EACC_W-1:0]   r_o_exp;
    logic [HACC_W-1:0]   r_o_hold;
    logic [TACC_W-1:0]   r_o_tok;
    logic [WACC_W-1:0]   r_o_wgt;
    logic                r_o_rej;

    logic                in_take;
    logic                out_free;
    t_pos                lo_pos;
    t_pos                blk_pos;
    t_pos                prev_pos;
    logic                rej_now;
    logic [EXP_W-1:0]    span_exp;
    logic [HOLD_W-1:0]   span_hold;
    logic [TOK_W-1:0]    span_tok;
    t_len                span_len;
    t_len                span_lm1;
    logic [MA_W-1:0]     mul_a;
    logic [MB_W-1:0]     mul_b;
    t_prod               mul_p;
    logic [HACC_W-1:0]   hold_add;

    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_ovalid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // 0 acts as 1, anything above the maximum acts as the maximum
    always_comb begin
        priority if (r_cfg_size == '0) begin
            size_eff = SIZE_W'(1);
        end else if (r_cfg_size > SIZE_W'(MAX_BUCKET_BLOCKS)) begin
            size_eff = SIZE_W'(MAX_BUCKET_BLOCKS);
        end else begin
            size_eff = r_cfg_size;
        end
    end

    assign lo_pos   = r_prod[POS_W-1:0];
    assign blk_pos  = {1'b0, r_in_blk};
    assign prev_pos = {1'b0, r_prev_blk};
    assign rej_now  = r_rej || (blk_pos > r_end) || (r_tail_valid && (prev_pos > r_end));

    // operands of the span in work
    always_comb begin
        if (r_span == SPAN_NEW) begin
            span_exp  = r_in_exp;
            span_hold = r_in_hold;
            span_tok  = r_in_tok;
        end else begin
            span_exp  = r_prev_exp;
            span_hold = r_prev_hold;
            span_tok  = r_prev_tok;
        end
        unique case (r_span)
            SPAN_DEL: span_len = r_l_del;
            SPAN_OLD: span_len = r_l_old;
            SPAN_NEW: span_len = r_l_new;
            default:  span_len = '0;
        endcase
        span_lm1 = (span_len == '0) ? '0 : span_len - LEN_W'(1);
    end

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_LO) begin
            mul_a = MA_W'(r_in_bidx);
            mul_b = MB_W'(r_size);
        end else begin
            unique case (r_op)
                OP_TRI: begin
                    mul_a = MA_W'(span_len);
                    mul_b = MB_W'(span_lm1);
                end
                OP_EXP: begin
                    mul_a = span_exp;
                    mul_b = MB_W'(span_len);
                end
                OP_HLO: begin
                    mul_a = MA_W'(span_hold[HALF_W-1:0]);
                    mul_b = MB_W'(span_len);
                end
                OP_HHI: begin
                    mul_a = MA_W'(span_hold[HOLD_W-1:HALF_W]);
                    mul_b = MB_W'(span_len);
                end
                OP_TOK: begin
                    mul_a = MA_W'(span_tok);
                    mul_b = MB_W'(span_len);
                end
                OP_HTRI: begin
                    mul_a = span_exp;
                    mul_b = MB_W'(r_tri);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // holding addend: low half as is, high half shifted up, slope term
    always_comb begin
        unique case (r_pkind)
            OP_HLO:  hold_add = HACC_W'(r_prod);
            OP_HHI:  hold_add = {r_prod[HACC_W-HALF_W-1:0], {HALF_W{1'b0}}};
            OP_HTRI: hold_add = HACC_W'(r_prod[EXP_W+TRI_W-1:0]);
            default: hold_add = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_take) n_state = S_LO;
            S_LO:    n_state = S_CHK;
            S_CHK:   n_state = S_LEN;
            S_LEN:   n_state = rej_now ? S_FIN : S_RUN;
            S_RUN:   if (r_op == OP_HTRI && r_span == SPAN_NEW) n_state = S_DRAIN;
            S_DRAIN: n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_size   <= SIZE_W'(1);
            r_tail_valid <= 1'b0;
            r_exp_acc    <= '0;
            r_hold_acc   <= '0;
            r_tok_acc    <= '0;
            r_wgt_acc    <= '0;
            r_pv         <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_RUN);

            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_size <= i_cfg_data;
            end

            // start of a bucket: drop tail and sums before this word
            if (in_take && s_axis_tuser[0]) begin
                r_tail_valid <= 1'b0;
                r_exp_acc    <= '0;
                r_hold_acc   <= '0;
                r_tok_acc    <= '0;
                r_wgt_acc    <= '0;
            end

            if (r_state == S_RUN && r_op == OP_TRI) begin
                r_wgt_acc <= (r_span == SPAN_DEL) ? r_wgt_acc - WACC_W'(span_len)
                                                  : r_wgt_acc + WACC_W'(span_len);
            end

            if (r_pv) begin
                unique case (r_pkind)
                    OP_EXP: begin
                        r_exp_acc <= r_psub ? r_exp_acc - r_prod[EACC_W-1:0]
                                            : r_exp_acc + r_prod[EACC_W-1:0];
                    end
                    OP_TOK: begin
                        r_tok_acc <= r_psub ? r_tok_acc - r_prod[TACC_W-1:0]
                                            : r_tok_acc + r_prod[TACC_W-1:0];
                    end
                    OP_HLO, OP_HHI, OP_HTRI: begin
                        r_hold_acc <= r_psub ? r_hold_acc - hold_add : r_hold_acc + hold_add;
                    end
                    default: begin
                    end
                endcase
            end

            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
                if (!r_rej) begin
                    r_tail_valid <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_bidx <= s_axis_tdata[27:0];
            r_in_blk  <= s_axis_tdata[67:28];
            r_in_exp  <= s_axis_tdata[103:68];
            r_in_hold <= s_axis_tdata[151:104];
            r_in_tok  <= s_axis_tdata[167:152];
            r_size    <= size_eff;
        end

        if (r_state == S_LO || r_state == S_RUN) begin
            r_prod  <= mul_p;
            r_pkind <= r_op;
            r_psub  <= (r_span == SPAN_DEL);
        end

        if (r_state == S_CHK) begin
            r_end <= lo_pos + POS_W'(r_size);
            r_rej <= (blk_pos < lo_pos) ||
                     (r_tail_valid && ((prev_pos < lo_pos) || (r_in_blk < r_prev_blk)));
        end

        if (r_state == S_LEN) begin
            r_rej   <= rej_now;
            r_l_del <= LEN_W'(r_end - prev_pos);
            r_l_old <= LEN_W'(blk_pos - prev_pos);
            r_l_new <= LEN_W'(r_end - blk_pos);
            r_span  <= r_tail_valid ? SPAN_DEL : SPAN_NEW;
            r_op    <= OP_TRI;
        end

        // advance op, then span
        if (r_state == S_RUN) begin
            if (r_op == OP_HTRI) begin
                r_op   <= OP_TRI;
                r_span <= r_span + 2'd1;
            end else begin
                r_op <= r_op + 3'd1;
            end
        end

        if (r_pv && r_pkind == OP_TRI) begin
            r_tri <= r_prod[TRI_W:1];
        end

        if (r_state == S_FIN && out_free) begin
            r_o_exp  <= r_exp_acc;
            r_o_hold <= r_hold_acc;
            r_o_tok  <= r_tok_acc;
            r_o_wgt  <= r_wgt_acc;
            r_o_rej  <= r_rej;
            if (!r_rej) begin
                r_prev_blk  <= r_in_blk;
                r_prev_exp  <= r_in_exp;
                r_prev_hold <= r_in_hold;
                r_prev_tok  <= r_in_tok;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_o_wgt, r_o_tok, r_o_hold, r_o_exp};
    assign m_axis_tuser  = r_o_rej;

    `include "time_weighted_tail_accumulator_unit_assert.svh"

    `TWTA_ASSERT_NOW(a_prod_in_run, r_pv, (r_state == S_RUN || r_state == S_DRAIN), "product pending outside the span sequence")
    `TWTA_ASSERT_NXT(a_rej_keeps_sums, (r_state == S_LEN && rej_now), ($stable(r_exp_acc) && $stable(r_hold_acc) && $stable(r_wgt_acc)), "dropped word changed the sums")
    `TWTA_ASSERT_NXT(a_fin_loads_out, (r_state == S_FIN && out_free), (m_axis_tvalid && r_state == S_IDLE), "finished word not moved to the output")

endmodule
